### hdl/apbt_pkg.sv
// Shared widths, codes and record types for the affine point and box transform unit.
package apbt_pkg;

    // Coordinate format: signed fixed point, COORD_WIDTH bits, FRAC_BITS fraction bits
    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;

    // Floored product, sums of up to five products and shifts, corner extents
    localparam int PROD_W = 2 * COORD_WIDTH - FRAC_BITS;
    localparam int SUM_W  = PROD_W + 3;
    localparam int EXT_W  = SUM_W + 1;

    // Stream payload widths, rounded up to whole bytes
    localparam int S_FIELDS_W = 2 + 4 * COORD_WIDTH;
    localparam int M_FIELDS_W = 2 * COORD_WIDTH + 2 * (COORD_WIDTH - 1) + 1;
    localparam int S_TDATA_W  = (S_FIELDS_W + 7) / 8 * 8;
    localparam int M_TDATA_W  = (M_FIELDS_W + 7) / 8 * 8;

    // Configuration port
    localparam int CFG_INDEX_W = 3;

    // Unity coefficient and saturation limits
    localparam logic [COORD_WIDTH-1:0] FIX_ONE = COORD_WIDTH'(1) << FRAC_BITS;
    localparam logic signed [EXT_W-1:0] SAT_HI =
        {{(EXT_W-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [EXT_W-1:0] SAT_LO =
        {{(EXT_W-COORD_WIDTH+1){1'b1}}, {(COORD_WIDTH-1){1'b0}}};

    typedef enum logic [1:0] {
        OP_POINT = 2'd0,
        OP_DIST  = 2'd1,
        OP_BOX   = 2'd2,
        OP_RSVD  = 2'd3
    } opcode_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_COEF_A  = 3'd0,
        CFG_COEF_B  = 3'd1,
        CFG_COEF_C  = 3'd2,
        CFG_COEF_D  = 3'd3,
        CFG_SHIFT_X = 3'd4,
        CFG_SHIFT_Y = 3'd5
    } cfg_index_t;

    // Captured request
    typedef struct packed {
        opcode_t                  op;
        logic signed [COORD_WIDTH-1:0] x;
        logic signed [COORD_WIDTH-1:0] y;
        logic signed [COORD_WIDTH-1:0] w;
        logic signed [COORD_WIDTH-1:0] h;
    } stage_in_t;

    // Floored products
    typedef struct packed {
        opcode_t                  op;
        logic signed [PROD_W-1:0] p_ax;
        logic signed [PROD_W-1:0] p_cy;
        logic signed [PROD_W-1:0] p_bx;
        logic signed [PROD_W-1:0] p_dy;
        logic signed [PROD_W-1:0] p_aw;
        logic signed [PROD_W-1:0] p_bw;
        logic signed [PROD_W-1:0] p_ch;
        logic signed [PROD_W-1:0] p_dh;
    } stage_prod_t;

    // Mapped corners
    typedef struct packed {
        opcode_t                 op;
        logic signed [SUM_W-1:0] cx0;
        logic signed [SUM_W-1:0] cx1;
        logic signed [SUM_W-1:0] cx2;
        logic signed [SUM_W-1:0] cx3;
        logic signed [SUM_W-1:0] cy0;
        logic signed [SUM_W-1:0] cy1;
        logic signed [SUM_W-1:0] cy2;
        logic signed [SUM_W-1:0] cy3;
    } stage_corner_t;

    // Corner extremes
    typedef struct packed {
        opcode_t                 op;
        logic signed [SUM_W-1:0] min_x;
        logic signed [SUM_W-1:0] max_x;
        logic signed [SUM_W-1:0] min_y;
        logic signed [SUM_W-1:0] max_y;
    } stage_ext_t;

    // Result record
    typedef struct packed {
        logic                     overflow;
        logic [COORD_WIDTH-2:0]   height_out;
        logic [COORD_WIDTH-2:0]   width_out;
        logic [COORD_WIDTH-1:0]   y_out;
        logic [COORD_WIDTH-1:0]   x_out;
    } result_t;

endpackage

### hdl/affine_point_and_box_transform_unit.sv
// Top level: five-stage affine transform of points, distances and bounding boxes.
//
// Use:
//   Requests arrive on the s_ stream (opcode, x, y, width, height) and one
//   result per request leaves on the m_ stream (x, y, width, height, overflow).
//   The six matrix registers are written through cfg_we/cfg_index/cfg_wdata
//   while no request is in flight; indexes 6 and 7 are ignored.
// Path: a request accepted into the input register moves on through the product,
//   corner, extreme and result registers before its result shows on m_tvalid.
// Throughput: one request per cycle unless stalled. Every stage has its own
//   register and the eight 32x32 multipliers are dedicated; nothing is shared between items.
// Reset: aresetn low at a clock edge empties the pipeline and loads the
//   identity matrix with zero translation.
// Stall: when m_tready is low the result holds; earlier stages keep filling
//   empty slots, and s_tready drops only once every stage is occupied.
module affine_point_and_box_transform_unit
    import apbt_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    // Configuration writes
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [COORD_WIDTH-1:0] cfg_wdata,
    // Request stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // s_tdata fields from bit 0: opcode, x_in, y_in, width_in, height_in, zero pad
    input  logic [S_TDATA_W-1:0]   s_tdata,
    // Result stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // m_tdata fields from bit 0: x_out, y_out, width_out, height_out, overflow, zero pad
    output logic [M_TDATA_W-1:0]   m_tdata
);

    // Matrix registers
    logic signed [COORD_WIDTH-1:0] coef_a_reg, coef_b_reg, coef_c_reg, coef_d_reg;
    logic signed [COORD_WIDTH-1:0] shift_x_reg, shift_y_reg;

    // Pipeline valids and payloads
    logic          v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic          rdy1, rdy2, rdy3, rdy4, rdy5;
    stage_in_t     s1_reg, s1_next;
    stage_prod_t   s2_reg, s2_next;
    stage_corner_t s3_reg, s3_next;
    stage_ext_t    s4_reg, s4_next;
    result_t       s5_reg, s5_next;

    // Take configuration writes; unknown indexes drop
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_a_reg  <= FIX_ONE;
            coef_b_reg  <= '0;
            coef_c_reg  <= '0;
            coef_d_reg  <= FIX_ONE;
            shift_x_reg <= '0;
            shift_y_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_COEF_A:  coef_a_reg  <= cfg_wdata;
                CFG_COEF_B:  coef_b_reg  <= cfg_wdata;
                CFG_COEF_C:  coef_c_reg  <= cfg_wdata;
                CFG_COEF_D:  coef_d_reg  <= cfg_wdata;
                CFG_SHIFT_X: shift_x_reg <= cfg_wdata;
                CFG_SHIFT_Y: shift_y_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // A stage loads when it is empty or its successor takes its contents
    assign rdy5     = !v5_reg || m_tready;
    assign rdy4     = !v4_reg || rdy5;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = rdy1;

    // Unpack the request
    always_comb begin
        s1_next.op = opcode_t'(s_tdata[1:0]);
        s1_next.x  = s_tdata[2+COORD_WIDTH-1 -: COORD_WIDTH];
        s1_next.y  = s_tdata[2+2*COORD_WIDTH-1 -: COORD_WIDTH];
        s1_next.w  = s_tdata[2+3*COORD_WIDTH-1 -: COORD_WIDTH];
        s1_next.h  = s_tdata[2+4*COORD_WIDTH-1 -: COORD_WIDTH];
    end

    // Multiply and floor to the fraction width by dropping low product bits
    logic signed [2*COORD_WIDTH-1:0] m_ax, m_cy, m_bx, m_dy, m_aw, m_bw, m_ch, m_dh;

    always_comb begin
        m_ax = coef_a_reg * s1_reg.x;
        m_cy = coef_c_reg * s1_reg.y;
        m_bx = coef_b_reg * s1_reg.x;
        m_dy = coef_d_reg * s1_reg.y;
        m_aw = coef_a_reg * s1_reg.w;
        m_bw = coef_b_reg * s1_reg.w;
        m_ch = coef_c_reg * s1_reg.h;
        m_dh = coef_d_reg * s1_reg.h;
        s2_next.op   = s1_reg.op;
        s2_next.p_ax = m_ax[2*COORD_WIDTH-1:FRAC_BITS];
        s2_next.p_cy = m_cy[2*COORD_WIDTH-1:FRAC_BITS];
        s2_next.p_bx = m_bx[2*COORD_WIDTH-1:FRAC_BITS];
        s2_next.p_dy = m_dy[2*COORD_WIDTH-1:FRAC_BITS];
        s2_next.p_aw = m_aw[2*COORD_WIDTH-1:FRAC_BITS];
        s2_next.p_bw = m_bw[2*COORD_WIDTH-1:FRAC_BITS];
        s2_next.p_ch = m_ch[2*COORD_WIDTH-1:FRAC_BITS];
        s2_next.p_dh = m_dh[2*COORD_WIDTH-1:FRAC_BITS];
    end

    // Map the corners; outside box mode all four collapse onto the origin
    logic signed [SUM_W-1:0] org_x, org_y, tx, ty, d1x, d1y, d2x, d2y;
    logic                    is_box, use_shift;

    always_comb begin
        is_box    = (s2_reg.op == OP_BOX);
        use_shift = (s2_reg.op == OP_POINT) || is_box;
        tx  = use_shift ? SUM_W'(shift_x_reg) : '0;
        ty  = use_shift ? SUM_W'(shift_y_reg) : '0;
        d1x = is_box ? SUM_W'(s2_reg.p_aw) : '0;
        d1y = is_box ? SUM_W'(s2_reg.p_bw) : '0;
        d2x = is_box ? SUM_W'(s2_reg.p_ch) : '0;
        d2y = is_box ? SUM_W'(s2_reg.p_dh) : '0;
        org_x = SUM_W'(s2_reg.p_ax) + SUM_W'(s2_reg.p_cy) + tx;
        org_y = SUM_W'(s2_reg.p_bx) + SUM_W'(s2_reg.p_dy) + ty;
        s3_next.op  = s2_reg.op;
        s3_next.cx0 = org_x;
        s3_next.cy0 = org_y;
        s3_next.cx1 = org_x + d1x;
        s3_next.cy1 = org_y + d1y;
        s3_next.cx2 = org_x + d2x;
        s3_next.cy2 = org_y + d2y;
        s3_next.cx3 = org_x + d1x + d2x;
        s3_next.cy3 = org_y + d1y + d2y;
    end

    // Find the corner extremes with a two-level compare tree
    logic signed [SUM_W-1:0] lo_x01, lo_x23, hi_x01, hi_x23;
    logic signed [SUM_W-1:0] lo_y01, lo_y23, hi_y01, hi_y23;

    always_comb begin
        lo_x01 = (s3_reg.cx1 < s3_reg.cx0) ? s3_reg.cx1 : s3_reg.cx0;
        hi_x01 = (s3_reg.cx1 > s3_reg.cx0) ? s3_reg.cx1 : s3_reg.cx0;
        lo_x23 = (s3_reg.cx3 < s3_reg.cx2) ? s3_reg.cx3 : s3_reg.cx2;
        hi_x23 = (s3_reg.cx3 > s3_reg.cx2) ? s3_reg.cx3 : s3_reg.cx2;
        lo_y01 = (s3_reg.cy1 < s3_reg.cy0) ? s3_reg.cy1 : s3_reg.cy0;
        hi_y01 = (s3_reg.cy1 > s3_reg.cy0) ? s3_reg.cy1 : s3_reg.cy0;
        lo_y23 = (s3_reg.cy3 < s3_reg.cy2) ? s3_reg.cy3 : s3_reg.cy2;
        hi_y23 = (s3_reg.cy3 > s3_reg.cy2) ? s3_reg.cy3 : s3_reg.cy2;
        s4_next.op    = s3_reg.op;
        s4_next.min_x = (lo_x23 < lo_x01) ? lo_x23 : lo_x01;
        s4_next.max_x = (hi_x23 > hi_x01) ? hi_x23 : hi_x01;
        s4_next.min_y = (lo_y23 < lo_y01) ? lo_y23 : lo_y01;
        s4_next.max_y = (hi_y23 > hi_y01) ? hi_y23 : hi_y01;
    end

    // Saturate origin and extents; the reserved opcode gives an all-zero result
    logic signed [EXT_W-1:0] lo_x, lo_y, ext_w, ext_h;
    logic                    sat_x_hi, sat_x_lo, sat_y_hi, sat_y_lo, sat_w, sat_h;
    logic [COORD_WIDTH-1:0]  hi_word, lo_word;

    always_comb begin
        hi_word  = SAT_HI[COORD_WIDTH-1:0];
        lo_word  = SAT_LO[COORD_WIDTH-1:0];
        lo_x     = EXT_W'(s4_reg.min_x);
        lo_y     = EXT_W'(s4_reg.min_y);
        ext_w    = EXT_W'(s4_reg.max_x) - EXT_W'(s4_reg.min_x);
        ext_h    = EXT_W'(s4_reg.max_y) - EXT_W'(s4_reg.min_y);
        sat_x_hi = lo_x > SAT_HI;
        sat_x_lo = lo_x < SAT_LO;
        sat_y_hi = lo_y > SAT_HI;
        sat_y_lo = lo_y < SAT_LO;
        sat_w    = ext_w > SAT_HI;
        sat_h    = ext_h > SAT_HI;
        s5_next.x_out      = sat_x_hi ? hi_word : (sat_x_lo ? lo_word : lo_x[COORD_WIDTH-1:0]);
        s5_next.y_out      = sat_y_hi ? hi_word : (sat_y_lo ? lo_word : lo_y[COORD_WIDTH-1:0]);
        s5_next.width_out  = sat_w ? hi_word[COORD_WIDTH-2:0] : ext_w[COORD_WIDTH-2:0];
        s5_next.height_out = sat_h ? hi_word[COORD_WIDTH-2:0] : ext_h[COORD_WIDTH-2:0];
        s5_next.overflow   = sat_x_hi || sat_x_lo || sat_y_hi || sat_y_lo || sat_w || sat_h;
        if (s4_reg.op == OP_RSVD) begin
            s5_next = '0;
        end
    end

    // Advance valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= s_tvalid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
            if (rdy5) v5_reg <= v4_reg;
        end
    end

    // Advance payloads
    always_ff @(posedge aclk) begin
        if (rdy1) s1_reg <= s1_next;
        if (rdy2) s2_reg <= s2_next;
        if (rdy3) s3_reg <= s3_next;
        if (rdy4) s4_reg <= s4_next;
        if (rdy5) s5_reg <= s5_next;
    end

    assign m_tvalid = v5_reg;
    assign m_tdata  = M_TDATA_W'(s5_reg);

    // The extremes are ordered
    a_extreme_order: assert property (@(posedge aclk) disable iff (!aresetn)
        v4_reg |-> (s4_reg.min_x <= s4_reg.max_x) && (s4_reg.min_y <= s4_reg.max_y))
        else $error("corner extremes out of order");

    // Outside box mode the corners coincide
    a_point_collapse: assert property (@(posedge aclk) disable iff (!aresetn)
        (v4_reg && s4_reg.op != OP_BOX) |->
            (s4_reg.min_x == s4_reg.max_x) && (s4_reg.min_y == s4_reg.max_y))
        else $error("non-box request has a non-zero extent");

    // A request handed on from the input register is not lost
    a_stage_handoff: assert property (@(posedge aclk) disable iff (!aresetn)
        (v1_reg && rdy2) |=> v2_reg)
        else $error("request dropped between input and product stages");

endmodule

### sim/affine_point_and_box_transform_unit_tb.sv
// Self-checking testbench for the affine point, distance and bounding-box transform unit.
`timescale 1ns / 100ps

module affine_point_and_box_transform_unit_tb
    import apbt_pkg::*;
();

    // Coordinate constants, Q16.16
    localparam logic [31:0] Q_ZERO    = 32'h0000_0000;
    localparam logic [31:0] Q_TWO     = 32'h0002_0000;
    localparam logic [31:0] Q_NEG_ONE = 32'hffff_0000;
    localparam logic [31:0] Q_ALL1    = 32'hffff_ffff;
    localparam logic [31:0] Q_MAX     = 32'h7fff_ffff;
    localparam logic [31:0] Q_MIN     = 32'h8000_0000;
    localparam logic [30:0] W_ZERO    = 31'h0000_0000;
    localparam logic [30:0] W_ONE     = 31'h0001_0000;
    localparam logic [30:0] W_TWO     = 31'h0002_0000;
    localparam logic [30:0] W_MAX     = 31'h7fff_ffff;
    localparam longint      COORD_HI  = 64'sh0000_0000_7fff_ffff;
    localparam longint      COORD_LO  = -COORD_HI - 1;

    // Register indexes the block must ignore
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_FIRST = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_LAST  = 3'd7;
    localparam int MATRIX_REGS = 6;

    // Matrix settings walked by the run
    localparam int SET_RESET   = 0;
    localparam int SET_ALL_MAX = 1;
    localparam int SET_ALL_MIN = 2;
    localparam int SET_WILD    = 3;
    localparam int MATRIX_SETTINGS = 10;

    localparam int DRAIN_CYCLES = 8;
    localparam int QUIET_LIMIT  = 2000;
    localparam int PROBE_ROWS   = 16;

    typedef struct {
        opcode_t     op;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] w;
        logic [31:0] h;
        bit          known;
        result_t     want;   // {overflow, height, width, y, x}
    } probe_row_t;

    // Directed requests, run under the reset matrix (identity, no translation)
    probe_row_t probe_table [PROBE_ROWS] = '{
        '{OP_POINT, FIX_ONE, Q_TWO, Q_ZERO, Q_ZERO, 1'b1,
          {1'b0, W_ZERO, W_ZERO, Q_TWO, FIX_ONE}},
        // width and height are ignored outside box mode
        '{OP_DIST, FIX_ONE, Q_TWO, Q_MAX, Q_MIN, 1'b1,
          {1'b0, W_ZERO, W_ZERO, Q_TWO, FIX_ONE}},
        '{OP_POINT, Q_MAX, Q_MIN, Q_ALL1, Q_ALL1, 1'b1,
          {1'b0, W_ZERO, W_ZERO, Q_MIN, Q_MAX}},
        '{OP_DIST, Q_MIN, Q_MAX, Q_ZERO, Q_ZERO, 1'b1,
          {1'b0, W_ZERO, W_ZERO, Q_MAX, Q_MIN}},
        '{OP_POINT, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, 1'b1,
          {1'b0, W_ZERO, W_ZERO, Q_ZERO, Q_ZERO}},
        '{OP_BOX, Q_ZERO, Q_ZERO, FIX_ONE, Q_TWO, 1'b1,
          {1'b0, W_TWO, W_ONE, Q_ZERO, Q_ZERO}},
        // negative size still gives a positive box
        '{OP_BOX, Q_ZERO, Q_ZERO, Q_NEG_ONE, Q_NEG_ONE, 1'b1,
          {1'b0, W_ONE, W_ONE, Q_NEG_ONE, Q_NEG_ONE}},
        // extent of exactly the largest value does not saturate
        '{OP_BOX, Q_MAX, Q_MIN, Q_MAX, Q_MAX, 1'b1,
          {1'b0, W_MAX, W_MAX, Q_MIN, Q_MAX}},
        // extent one past the largest value saturates on its own
        '{OP_BOX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, 1'b1,
          {1'b1, W_MAX, W_MAX, Q_ALL1, Q_ALL1}},
        // corner below the range: minimum and extent both saturate
        '{OP_BOX, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 1'b1,
          {1'b1, W_MAX, W_MAX, Q_MIN, Q_MIN}},
        '{OP_BOX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 1'b1,
          {1'b0, W_MAX, W_MAX, Q_MAX, Q_MAX}},
        // reserved opcode returns all zeros
        '{OP_RSVD, Q_ALL1, Q_ALL1, Q_ALL1, Q_ALL1, 1'b1,
          {1'b0, W_ZERO, W_ZERO, Q_ZERO, Q_ZERO}},
        '{OP_RSVD, FIX_ONE, Q_TWO, FIX_ONE, Q_TWO, 1'b1,
          {1'b0, W_ZERO, W_ZERO, Q_ZERO, Q_ZERO}},
        '{OP_POINT, 32'h0000_0001, Q_ALL1, Q_ZERO, Q_ZERO, 1'b0, '0},
        '{OP_DIST, 32'h1234_5678, 32'hedcb_a988, FIX_ONE, FIX_ONE, 1'b0, '0},
        '{OP_BOX, 32'h0000_0001, Q_ALL1, Q_ALL1, 32'h0000_0001, 1'b0, '0}
    };

    // DUT ports
    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [COORD_WIDTH-1:0] cfg_wdata = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;

    // Predictor copy of the matrix registers, indexed by register
    logic signed [COORD_WIDTH-1:0] matrix [MATRIX_REGS];
    logic [31:0]                   matrix_next [MATRIX_REGS];

    result_t expected_results [$];
    result_t got_result;
    result_t want_result;
    int      mismatch_count  = 0;
    int      results_checked = 0;
    int      sent_count      = 0;
    int      quiet_cycles    = 0;
    int      send_idle_pct   = 30;
    int      recv_idle_pct   = 48;

    affine_point_and_box_transform_unit u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // 50 MHz clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Product of two coordinates, floored back to FRAC_BITS fraction bits
    function automatic longint floor_mul(input logic signed [31:0] p,
                                         input logic signed [31:0] q);
        longint prod;
        prod = longint'(p) * longint'(q);
        return prod >>> FRAC_BITS;
    endfunction

    function automatic logic [31:0] clamp_coord(input longint v, inout bit ovf);
        if (v > COORD_HI) begin
            ovf = 1'b1;
            return Q_MAX;
        end
        if (v < COORD_LO) begin
            ovf = 1'b1;
            return Q_MIN;
        end
        return 32'(v);
    endfunction

    function automatic logic [30:0] clamp_extent(input longint v, inout bit ovf);
        if (v > COORD_HI) begin
            ovf = 1'b1;
            return W_MAX;
        end
        return 31'(v);
    endfunction

    // Expected result of one request under the current matrix
    function automatic result_t predict_transform(input opcode_t op,
                                                  input logic signed [31:0] x,
                                                  input logic signed [31:0] y,
                                                  input logic signed [31:0] w,
                                                  input logic signed [31:0] h);
        result_t r;
        bit      ovf;
        longint  px, py, d1x, d1y, d2x, d2y;
        longint  cx [4];
        longint  cy [4];
        longint  lo_x, hi_x, lo_y, hi_y;
        r   = '0;
        ovf = 1'b0;
        px  = floor_mul(matrix[CFG_COEF_A], x) + floor_mul(matrix[CFG_COEF_C], y);
        py  = floor_mul(matrix[CFG_COEF_B], x) + floor_mul(matrix[CFG_COEF_D], y);
        case (op) inside
            OP_POINT, OP_DIST: begin
                if (op == OP_POINT) begin
                    px += longint'(matrix[CFG_SHIFT_X]);
                    py += longint'(matrix[CFG_SHIFT_Y]);
                end
                r.x_out = clamp_coord(px, ovf);
                r.y_out = clamp_coord(py, ovf);
            end
            OP_BOX: begin
                px += longint'(matrix[CFG_SHIFT_X]);
                py += longint'(matrix[CFG_SHIFT_Y]);
                d1x = floor_mul(matrix[CFG_COEF_A], w);
                d1y = floor_mul(matrix[CFG_COEF_B], w);
                d2x = floor_mul(matrix[CFG_COEF_C], h);
                d2y = floor_mul(matrix[CFG_COEF_D], h);
                cx[0] = px;             cy[0] = py;
                cx[1] = px + d1x;       cy[1] = py + d1y;
                cx[2] = px + d2x;       cy[2] = py + d2y;
                cx[3] = px + d1x + d2x; cy[3] = py + d1y + d2y;
                lo_x = cx[0]; hi_x = cx[0];
                lo_y = cy[0]; hi_y = cy[0];
                for (int i = 1; i < 4; i++) begin
                    if (cx[i] < lo_x) lo_x = cx[i];
                    if (cx[i] > hi_x) hi_x = cx[i];
                    if (cy[i] < lo_y) lo_y = cy[i];
                    if (cy[i] > hi_y) hi_y = cy[i];
                end
                // extents come from the unsaturated corners
                r.x_out      = clamp_coord(lo_x, ovf);
                r.y_out      = clamp_coord(lo_y, ovf);
                r.width_out  = clamp_extent(hi_x - lo_x, ovf);
                r.height_out = clamp_extent(hi_y - lo_y, ovf);
            end
            default: begin
            end
        endcase
        r.overflow = ovf;
        return r;
    endfunction

    // Random coordinate: full range, small, medium or one of the edge values
    function automatic logic [31:0] random_coord();
        case ($urandom_range(5))
            0, 1: return $urandom;
            2:    return 32'($urandom_range(2**21)) - 32'(2**20);
            3: begin
                case ($urandom_range(4))
                    0:       return Q_MAX;
                    1:       return Q_MIN;
                    2:       return Q_ALL1;
                    3:       return Q_ZERO;
                    default: return FIX_ONE;
                endcase
            end
            default: return 32'($urandom_range(2**28)) - 32'(2**27);
        endcase
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: result %0d %s: got %h, expected %h",
                 $realtime, results_checked, field, got, want);
        mismatch_count++;
    endtask

    // Present one request and hold it until accepted
    task automatic send_request(input opcode_t op, input logic [31:0] x,
                                input logic [31:0] y, input logic [31:0] w,
                                input logic [31:0] h, input bit known,
                                input result_t want);
        // idle pattern: receiver-heavy, then sender-heavy, then none
        if (sent_count < 200) begin
            send_idle_pct = 30;
            recv_idle_pct = 48;
        end else if (sent_count < 400) begin
            send_idle_pct = 48;
            recv_idle_pct = 30;
        end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'({h, w, y, x, op});
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_results.push_back(known ? want : predict_transform(op, x, y, w, h));
        sent_count++;
    endtask

    // Hold off requests until every result is back and the pipeline is empty
    task automatic settle_pipeline();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Load all six matrix registers, then poke the unused indexes
    task automatic write_registers(input logic [31:0] vals [MATRIX_REGS]);
        for (int i = 0; i < MATRIX_REGS; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= cfg_index_t'(i);
            cfg_wdata <= vals[i];
            @(posedge aclk);
            matrix[i] = vals[i];
        end
        cfg_index <= CFG_UNUSED_FIRST;
        cfg_wdata <= $urandom;
        @(posedge aclk);
        cfg_index <= CFG_UNUSED_LAST;
        cfg_wdata <= $urandom;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Result side back-pressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Compare each result with the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_result = result_t'(m_tdata[M_FIELDS_W-1:0]);
            results_checked++;
            if (expected_results.size() == 0) begin
                report_mismatch("unrequested, x_out", got_result.x_out, Q_ZERO);
            end else begin
                want_result = expected_results.pop_front();
                if (got_result.x_out !== want_result.x_out)
                    report_mismatch("x_out", got_result.x_out, want_result.x_out);
                if (got_result.y_out !== want_result.y_out)
                    report_mismatch("y_out", got_result.y_out, want_result.y_out);
                if (got_result.width_out !== want_result.width_out)
                    report_mismatch("width_out", got_result.width_out,
                                    want_result.width_out);
                if (got_result.height_out !== want_result.height_out)
                    report_mismatch("height_out", got_result.height_out,
                                    want_result.height_out);
                if (got_result.overflow !== want_result.overflow)
                    report_mismatch("overflow", got_result.overflow,
                                    want_result.overflow);
            end
        end
    end

    // Abort when neither stream moves for too long
    always @(posedge aclk) begin
        if (aresetn && ((s_tvalid && s_tready) || (m_tvalid && m_tready)))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no request or result moved for %0d cycles",
                     $realtime, QUIET_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    // Main sequence
    initial begin
        matrix[CFG_COEF_A]  = FIX_ONE;
        matrix[CFG_COEF_B]  = '0;
        matrix[CFG_COEF_C]  = '0;
        matrix[CFG_COEF_D]  = FIX_ONE;
        matrix[CFG_SHIFT_X] = '0;
        matrix[CFG_SHIFT_Y] = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        for (int setting = 0; setting < MATRIX_SETTINGS; setting++) begin
            if (setting == SET_RESET) begin
                foreach (probe_table[r])
                    send_request(probe_table[r].op, probe_table[r].x, probe_table[r].y,
                                 probe_table[r].w, probe_table[r].h,
                                 probe_table[r].known, probe_table[r].want);
            end else begin
                // pick the next matrix: extremes first, then random ones
                for (int i = 0; i < MATRIX_REGS; i++) begin
                    case (setting)
                        SET_ALL_MAX: matrix_next[i] = Q_MAX;
                        SET_ALL_MIN: matrix_next[i] = Q_MIN;
                        SET_WILD:    matrix_next[i] = $urandom;
                        default: begin
                            if (i < CFG_SHIFT_X)
                                matrix_next[i] = 32'($urandom_range(2**19)) - 32'(2**18);
                            else
                                matrix_next[i] = random_coord();
                        end
                    endcase
                end
                settle_pipeline();
                write_registers(matrix_next);
            end
            repeat (setting == SET_RESET ? 40 : 60)
                send_request(($urandom_range(7) == 0) ? OP_RSVD
                                                      : opcode_t'($urandom_range(2)),
                             random_coord(), random_coord(), random_coord(),
                             random_coord(), 1'b0, '0);
        end

        settle_pipeline();
        $display("Covered %0d requests (%0d directed) over %0d matrix settings, extremes included,",
                 sent_count, PROBE_ROWS, MATRIX_SETTINGS);
        $display("all four opcodes, saturation and negative box sizes; %0d results checked.",
                 results_checked);
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

### files.f
hdl/apbt_pkg.sv
hdl/affine_point_and_box_transform_unit.sv
sim/affine_point_and_box_transform_unit_tb.sv
